/* rtl/core/trsmc_pkg.sv */
// Shared types, widths and arithmetic helpers for the TRS matrix composer.
// No dependencies; used by every module under rtl/core.
package trsmc_pkg;

	// field widths
	localparam int POS_W   = 32;              // Q16.16 position
	localparam int QUAT_W  = 16;              // Q1.14 quaternion part
	localparam int SCALE_W = 16;              // Q8.8 scale
	localparam int OUT_W   = 32;              // Q16.16 result
	localparam int PROD_W  = 2 * QUAT_W;      // quaternion part product, Q.28
	localparam int ELEM_W  = PROD_W + 2;      // rotation element, Q.28 with headroom
	localparam int MUL_W   = ELEM_W + SCALE_W; // element times scale, Q.36
	localparam int RND_SH  = 20;              // Q.36 -> Q.16
	localparam int NUM_ELEM = 9;
	localparam int NUM_OUT  = 12;

	localparam int IN_TDATA_W  = 3 * POS_W + 4 * QUAT_W + 3 * SCALE_W;   // 208
	localparam int OUT_TDATA_W = NUM_OUT * OUT_W;                       // 384

	// quaternion part slots
	localparam int QW = 0;
	localparam int QX = 1;
	localparam int QY = 2;
	localparam int QZ = 3;

	// one in Q.28
	localparam logic signed [ELEM_W-1:0] ONE_Q28 = ELEM_W'(1) << 28;

	// input beat; member order makes the struct match the tdata packing
	// (pos_x in the lowest bits, scale_z in the highest)
	typedef struct packed {
		logic [2:0][SCALE_W-1:0] scale;   // x, y, z
		logic [3:0][QUAT_W-1:0]  quat;    // w, x, y, z
		logic [2:0][POS_W-1:0]   pos;     // x, y, z
	} item_t;

	// beat between rotation and scaling units; element k = column*3 + row
	typedef struct packed {
		logic [NUM_ELEM-1:0][ELEM_W-1:0] elem;
		logic [2:0][SCALE_W-1:0]         scale;
		logic [2:0][POS_W-1:0]           pos;
	} rot_beat_t;

	// result beat: nine matrix words then the translation column
	typedef logic [NUM_OUT-1:0][OUT_W-1:0] result_t;

	// valid/ready pair between pipeline sections
	typedef struct packed {
		logic valid;
	} fwd_ctl_t;

	typedef struct packed {
		logic ready;
	} bwd_ctl_t;

	// round half up from Q.36 to Q.16, then saturate to 32 bits
	function automatic logic [OUT_W-1:0] round_sat(input logic signed [MUL_W-1:0] p);
		logic signed [MUL_W:0] sum;
		logic signed [MUL_W:0] shr;
		logic signed [MUL_W:0] max_v;
		logic signed [MUL_W:0] min_v;
		logic [OUT_W-1:0]      res;
		sum   = (MUL_W+1)'(p) + ((MUL_W+1)'(1) <<< (RND_SH - 1));
		shr   = sum >>> RND_SH;
		max_v = (MUL_W+1)'({1'b0, {(OUT_W-1){1'b1}}});
		min_v = -max_v - (MUL_W+1)'(1);
		if (shr > max_v) begin
			res = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (shr < min_v) begin
			res = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			res = shr[OUT_W-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/core/trsmc_quat_rot.sv */
// Rotation section: quaternion part products (stage 1), rotation elements (stage 2).
// Depends on trsmc_pkg.
module trsmc_quat_rot (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trsmc_pkg::fwd_ctl_t  up_fwd,
	output trsmc_pkg::bwd_ctl_t  up_bwd,
	input  trsmc_pkg::item_t     up_item,
	output trsmc_pkg::fwd_ctl_t  dn_fwd,
	input  trsmc_pkg::bwd_ctl_t  dn_bwd,
	output trsmc_pkg::rot_beat_t dn_beat
);

	localparam int PW = trsmc_pkg::PROD_W;
	localparam int EW = trsmc_pkg::ELEM_W;

	logic valid_s1;
	logic valid_s2;
	logic rdy_s1;
	logic rdy_s2;

	// stage 1 payload
	logic signed [PW-1:0] xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] xy_s1, xz_s1, yz_s1;
	logic signed [PW-1:0] wx_s1, wy_s1, wz_s1;
	logic [2:0][trsmc_pkg::SCALE_W-1:0] scale_s1;
	logic [2:0][trsmc_pkg::POS_W-1:0]   pos_s1;

	// stage 2 payload
	trsmc_pkg::rot_beat_t beat_s2;

	logic signed [trsmc_pkg::QUAT_W-1:0] qw, qx, qy, qz;
	logic signed [EW-1:0] xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
	logic [trsmc_pkg::NUM_ELEM-1:0][EW-1:0] elem_c;

	// a stage takes a beat when empty or when its beat moves on
	assign rdy_s2       = !valid_s2 || dn_bwd.ready;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign up_bwd.ready = rdy_s1;

	assign qw = $signed(up_item.quat[trsmc_pkg::QW]);
	assign qx = $signed(up_item.quat[trsmc_pkg::QX]);
	assign qy = $signed(up_item.quat[trsmc_pkg::QY]);
	assign qz = $signed(up_item.quat[trsmc_pkg::QZ]);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= up_fwd.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	// stage 1: nine 16x16 products
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_fwd.valid) begin
			xx_s1    <= PW'(qx) * PW'(qx);
			yy_s1    <= PW'(qy) * PW'(qy);
			zz_s1    <= PW'(qz) * PW'(qz);
			xy_s1    <= PW'(qx) * PW'(qy);
			xz_s1    <= PW'(qx) * PW'(qz);
			yz_s1    <= PW'(qy) * PW'(qz);
			wx_s1    <= PW'(qw) * PW'(qx);
			wy_s1    <= PW'(qw) * PW'(qy);
			wz_s1    <= PW'(qw) * PW'(qz);
			scale_s1 <= up_item.scale;
			pos_s1   <= up_item.pos;
		end
	end

	// sign-extend products to element width
	assign xx_e = EW'(xx_s1);
	assign yy_e = EW'(yy_s1);
	assign zz_e = EW'(zz_s1);
	assign xy_e = EW'(xy_s1);
	assign xz_e = EW'(xz_s1);
	assign yz_e = EW'(yz_s1);
	assign wx_e = EW'(wx_s1);
	assign wy_e = EW'(wy_s1);
	assign wz_e = EW'(wz_s1);

	// rotation matrix, column-major: index = column*3 + row
	always_comb begin
		elem_c[0] = trsmc_pkg::ONE_Q28 - ((yy_e + zz_e) <<< 1);
		elem_c[1] = (xy_e + wz_e) <<< 1;
		elem_c[2] = (xz_e - wy_e) <<< 1;
		elem_c[3] = (xy_e - wz_e) <<< 1;
		elem_c[4] = trsmc_pkg::ONE_Q28 - ((xx_e + zz_e) <<< 1);
		elem_c[5] = (yz_e + wx_e) <<< 1;
		elem_c[6] = (xz_e + wy_e) <<< 1;
		elem_c[7] = (yz_e - wx_e) <<< 1;
		elem_c[8] = trsmc_pkg::ONE_Q28 - ((xx_e + yy_e) <<< 1);
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			beat_s2.elem  <= elem_c;
			beat_s2.scale <= scale_s1;
			beat_s2.pos   <= pos_s1;
		end
	end

	assign dn_fwd.valid = valid_s2;
	assign dn_beat      = beat_s2;

endmodule

/* rtl/core/trsmc_scale_sat.sv */
// Scaling section: element times axis scale (stage 3), round and saturate (stage 4).
// Depends on trsmc_pkg. Stage 4 is the output register.
module trsmc_scale_sat (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trsmc_pkg::fwd_ctl_t  up_fwd,
	output trsmc_pkg::bwd_ctl_t  up_bwd,
	input  trsmc_pkg::rot_beat_t up_beat,
	output trsmc_pkg::fwd_ctl_t  dn_fwd,
	input  trsmc_pkg::bwd_ctl_t  dn_bwd,
	output trsmc_pkg::result_t   dn_res
);

	localparam int MW = trsmc_pkg::MUL_W;
	localparam int NE = trsmc_pkg::NUM_ELEM;

	logic valid_s3;
	logic valid_s4;
	logic rdy_s3;
	logic rdy_s4;

	logic signed [MW-1:0]             prod_s3 [NE];
	logic [2:0][trsmc_pkg::POS_W-1:0] pos_s3;
	logic signed [MW-1:0]             prod_c  [NE];
	trsmc_pkg::result_t               res_s4;
	trsmc_pkg::result_t               res_c;

	assign rdy_s4       = !valid_s4 || dn_bwd.ready;
	assign rdy_s3       = !valid_s3 || rdy_s4;
	assign up_bwd.ready = rdy_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s3) valid_s3 <= up_fwd.valid;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// nine element x scale multipliers, scale picked by column
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				prod_c[c*3+r] = MW'($signed(up_beat.elem[c*3+r])) *
					MW'($signed(up_beat.scale[c]));
			end
		end
	end

	// stage 3 register
	always_ff @(posedge clk) begin
		if (rdy_s3 && up_fwd.valid) begin
			prod_s3 <= prod_c;
			pos_s3  <= up_beat.pos;
		end
	end

	// round to Q16.16 and saturate; translation passes through
	always_comb begin
		for (int k = 0; k < NE; k++) begin
			res_c[k] = trsmc_pkg::round_sat(prod_s3[k]);
		end
		for (int a = 0; a < 3; a++) begin
			res_c[NE+a] = pos_s3[a];
		end
	end

	// stage 4 / output register
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			res_s4 <= res_c;
		end
	end

	assign dn_fwd.valid = valid_s4;
	assign dn_res       = res_s4;

endmodule

/* rtl/core/trs_matrix_compose.sv */
// Top level of the TRS matrix composer: stream ports around two pipeline sections.
// Depends on trsmc_pkg, trsmc_quat_rot, trsmc_scale_sat.
//
//   channel   direction   beat
//   s_axis    in          position, quaternion, scale (one transform)
//   m_axis    out         3x4 affine matrix T*R*S
//
// Four register stages: part products, rotation elements, scale multiply,
// round/saturate (output register). One beat per cycle while m_tready is high.
// Each stage holds its own valid bit and takes a beat when empty or draining,
// so bubbles close up under a stall and nothing is dropped or repeated.
// Reset clears the valid bits only.
module trs_matrix_compose (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
	input  logic [trsmc_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2, t_x, t_y, t_z
	output logic [trsmc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	trsmc_pkg::item_t     in_item;
	trsmc_pkg::fwd_ctl_t  in_fwd;
	trsmc_pkg::bwd_ctl_t  in_bwd;
	trsmc_pkg::fwd_ctl_t  mid_fwd;
	trsmc_pkg::bwd_ctl_t  mid_bwd;
	trsmc_pkg::rot_beat_t mid_beat;
	trsmc_pkg::fwd_ctl_t  out_fwd;
	trsmc_pkg::bwd_ctl_t  out_bwd;
	trsmc_pkg::result_t   out_res;

	// struct layout matches the tdata field order
	assign in_item       = s_tdata;
	assign in_fwd.valid  = s_tvalid;
	assign s_tready      = in_bwd.ready;

	trsmc_quat_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_fwd  (in_fwd),
		.up_bwd  (in_bwd),
		.up_item (in_item),
		.dn_fwd  (mid_fwd),
		.dn_bwd  (mid_bwd),
		.dn_beat (mid_beat)
	);

	trsmc_scale_sat u_scl (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_fwd  (mid_fwd),
		.up_bwd  (mid_bwd),
		.up_beat (mid_beat),
		.dn_fwd  (out_fwd),
		.dn_bwd  (out_bwd),
		.dn_res  (out_res)
	);

	assign out_bwd.ready = m_tready;
	assign m_tvalid      = out_fwd.valid;
	assign m_tdata       = out_res;

endmodule
